### rtl/core/dcst_pkg.sv
// ----------------------------------------------------------------------------
// Divisor count sieve table package
// Shared codes, controller states and divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package dcst_pkg;

  localparam int unsigned DIV_W = 16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_OUT,
    S_INIT,
    S_SCHK,
    S_SI,
    S_JRD,
    S_JWR,
    S_DCHK,
    S_DP,
    S_DDIV1,
    S_DM,
    S_DDIV2,
    S_B_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/dcst_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [$clog2(DEPTH)-1:0]    waddr_i,
  input  wire  [WIDTH-1:0]            wdata_i,
  input  wire                         re_i,
  input  wire  [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [WIDTH-1:0]            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/dcst_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcst_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dcst_pkg::div_req_t  req_i,
  output dcst_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned W = dcst_pkg::DIV_W;

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] dvs_q, dvs_d;
  logic [W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'(W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### rtl/core/divisor_count_sieve_table_unit.sv
// ----------------------------------------------------------------------------
// Divisor count sieve table unit
// Builds smallest prime factor, exponent and divisor count tables and answers
// queries from them.
// ----------------------------------------------------------------------------
// Usage: an input item carries the command in tuser (0 build, 1 query) and the
// number in tdata. Every item gives exactly one result item in order.
// A query makes one synchronous read of the three tables, then the result is
// loaded into the output register.
// A build occupies the block: it seeds the factor table with one write per
// entry, makes a read and a write per sieve marking, and for each composite n
// runs two passes of the divider (n/p, then the divisor count of n/p over the
// exponent). The divider passes dominate the build time.
// The build result (status ok) follows the last write.
// Reset clears the control state and the tables-built flag and sets the
// limit to 65535; table contents are undefined until a build.
// Writing the limit marks the tables as not built.
// A result waits in the output register while the receiver stalls; no new
// item is taken until it has been loaded there.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_count_sieve_table_unit #(
  parameter int unsigned MAX_N = 65535
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // number
  input  wire         s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status, smallest_prime, prime_exponent, divisor_count, is_prime
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned TOP_MAX = (MAX_N > 65535) ? 65535 : MAX_N;
  localparam int unsigned DEPTH   = TOP_MAX + 1;
  localparam int unsigned AW      = $clog2(DEPTH);

  dcst_pkg::state_e state_q, state_d;

  logic [15:0]   limit_q;
  logic          ready_q, ready_d;
  logic [AW-1:0] top;
  logic [AW-1:0] i_q, i_d;
  logic [AW:0]   j_q, j_d;
  logic [AW:0]   n_q, n_d;
  logic [AW-1:0] m_q, m_d;
  logic [AW-1:0] p_q, p_d;
  logic [5:0]    a_q, a_d;
  logic [5:0]    a_new;
  logic [15:0]   num_q, num_d;
  logic [1:0]    st_q, st_d;
  logic          one_q, one_d;
  logic [2*AW-1:0] sq;
  logic [13:0]   prod;

  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;
  logic          out_load;

  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          spf_we;
  logic [AW-1:0] spf_waddr;
  logic [AW-1:0] spf_wdata;
  logic          ed_we;
  logic [4:0]    exp_wdata;
  logic [7:0]    div_wdata;
  logic [AW-1:0] spf_rd;
  logic [4:0]    exp_rd;
  logic [7:0]    div_rd;

  dcst_pkg::div_req_t div_req;
  dcst_pkg::div_rsp_t div_rsp;

  logic [31:0] q_result;

  always_comb begin
    if (32'(limit_q) > 32'(TOP_MAX)) begin
      top = AW'(TOP_MAX);
    end else begin
      top = limit_q[AW-1:0];
    end
  end

  assign sq    = (2*AW)'(i_q) * (2*AW)'(i_q);
  assign prod  = 14'(div_rsp.quotient[7:0]) * 14'(a_q + 6'd1);
  assign a_new = ((m_q >= AW'(2)) && (spf_rd == p_q)) ? (6'(exp_rd) + 6'd1) : 6'd1;

  assign s_axis_tready = (state_q == dcst_pkg::S_IDLE);
  assign out_load = ((state_q == dcst_pkg::S_Q_OUT) || (state_q == dcst_pkg::S_B_OUT)) &&
                    (!out_valid_q || m_axis_tready);

  always_comb begin
    q_result = '0;
    q_result[1:0] = st_q;
    if (st_q == dcst_pkg::STATUS_OK) begin
      if (one_q) begin
        q_result[30:23] = 8'd1;
      end else begin
        q_result[17:2]  = 16'(spf_rd);
        q_result[22:18] = exp_rd;
        q_result[30:23] = div_rd;
        q_result[31]    = (16'(spf_rd) == num_q);
      end
    end
  end

  // Next state and register updates.
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    i_d     = i_q;
    j_d     = j_q;
    n_d     = n_q;
    m_d     = m_q;
    p_d     = p_q;
    a_d     = a_q;
    num_d   = num_q;
    st_d    = st_q;
    one_d   = one_q;
    unique case (state_q)
      dcst_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          num_d = s_axis_tdata;
          one_d = (s_axis_tdata == 16'd1);
          if (!s_axis_tuser) begin
            st_d    = dcst_pkg::STATUS_OK;
            i_d     = AW'(2);
            state_d = dcst_pkg::S_INIT;
          end else begin
            if (!ready_q) begin
              st_d = dcst_pkg::STATUS_NOT_BUILT;
            end else if ((s_axis_tdata == 16'd0) || (32'(s_axis_tdata) > 32'(top))) begin
              st_d = dcst_pkg::STATUS_RANGE;
            end else begin
              st_d = dcst_pkg::STATUS_OK;
            end
            state_d = dcst_pkg::S_Q_OUT;
          end
        end
      end
      dcst_pkg::S_Q_OUT, dcst_pkg::S_B_OUT: begin
        if (out_load) begin
          state_d = dcst_pkg::S_IDLE;
        end
      end
      dcst_pkg::S_INIT: begin
        if ((AW+1)'(i_q) > (AW+1)'(top) || i_q < AW'(2)) begin
          i_d     = AW'(2);
          state_d = dcst_pkg::S_SCHK;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      dcst_pkg::S_SCHK: begin
        if (sq > (2*AW)'(top)) begin
          n_d     = (AW+1)'(2);
          state_d = dcst_pkg::S_DCHK;
        end else begin
          state_d = dcst_pkg::S_SI;
        end
      end
      dcst_pkg::S_SI: begin
        if (spf_rd == i_q) begin
          j_d     = sq[AW:0];
          state_d = dcst_pkg::S_JRD;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = dcst_pkg::S_SCHK;
        end
      end
      dcst_pkg::S_JRD: begin
        if (j_q > (AW+1)'(top)) begin
          i_d     = i_q + AW'(1);
          state_d = dcst_pkg::S_SCHK;
        end else begin
          state_d = dcst_pkg::S_JWR;
        end
      end
      dcst_pkg::S_JWR: begin
        j_d     = j_q + (AW+1)'(i_q);
        state_d = dcst_pkg::S_JRD;
      end
      dcst_pkg::S_DCHK: begin
        if (n_q > (AW+1)'(top)) begin
          ready_d = 1'b1;
          state_d = dcst_pkg::S_B_OUT;
        end else begin
          state_d = dcst_pkg::S_DP;
        end
      end
      dcst_pkg::S_DP: begin
        if ((spf_rd == n_q[AW-1:0]) || (spf_rd < AW'(2))) begin
          n_d     = n_q + (AW+1)'(1);
          state_d = dcst_pkg::S_DCHK;
        end else begin
          p_d     = spf_rd;
          state_d = dcst_pkg::S_DDIV1;
        end
      end
      dcst_pkg::S_DDIV1: begin
        if (div_rsp.done) begin
          m_d     = div_rsp.quotient[AW-1:0];
          state_d = dcst_pkg::S_DM;
        end
      end
      dcst_pkg::S_DM: begin
        a_d     = a_new;
        state_d = dcst_pkg::S_DDIV2;
      end
      dcst_pkg::S_DDIV2: begin
        if (div_rsp.done) begin
          n_d     = n_q + (AW+1)'(1);
          state_d = dcst_pkg::S_DCHK;
        end
      end
      default: begin
        state_d = dcst_pkg::S_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      ready_d = 1'b0;
    end
  end

  // Memory, divider and output register controls.
  always_comb begin
    rd_en       = 1'b0;
    raddr       = i_q;
    spf_we      = 1'b0;
    spf_waddr   = i_q;
    spf_wdata   = i_q;
    ed_we       = 1'b0;
    exp_wdata   = 5'd1;
    div_wdata   = 8'd2;
    div_req     = '0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    unique case (state_q)
      dcst_pkg::S_IDLE: begin
        rd_en = s_axis_tvalid && s_axis_tuser;
        raddr = s_axis_tdata[AW-1:0];
      end
      dcst_pkg::S_INIT: begin
        spf_we = ((AW+1)'(i_q) <= (AW+1)'(top)) && (i_q >= AW'(2));
      end
      dcst_pkg::S_SCHK: begin
        rd_en = 1'b1;
      end
      dcst_pkg::S_JRD: begin
        rd_en = 1'b1;
        raddr = j_q[AW-1:0];
      end
      dcst_pkg::S_JWR: begin
        spf_waddr = j_q[AW-1:0];
        spf_we    = (spf_rd == j_q[AW-1:0]);
      end
      dcst_pkg::S_DCHK: begin
        rd_en = 1'b1;
        raddr = n_q[AW-1:0];
      end
      dcst_pkg::S_DP: begin
        if ((spf_rd == n_q[AW-1:0]) || (spf_rd < AW'(2))) begin
          ed_we = 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 16'(n_q[AW-1:0]);
          div_req.divisor  = 16'(spf_rd);
        end
      end
      dcst_pkg::S_DDIV1: begin
        rd_en = div_rsp.done;
        raddr = div_rsp.quotient[AW-1:0];
      end
      dcst_pkg::S_DM: begin
        div_req.start    = 1'b1;
        div_req.dividend = 16'(div_rd);
        div_req.divisor  = 16'(a_new);
      end
      dcst_pkg::S_DDIV2: begin
        ed_we     = div_rsp.done;
        exp_wdata = a_q[4:0];
        div_wdata = prod[7:0];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = (state_q == dcst_pkg::S_Q_OUT) ? q_result : 32'(dcst_pkg::STATUS_OK);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcst_pkg::S_IDLE;
      ready_q     <= 1'b0;
      limit_q     <= 16'hFFFF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    n_q        <= n_d;
    m_q        <= m_d;
    p_q        <= p_d;
    a_q        <= a_d;
    num_q      <= num_d;
    st_q       <= st_d;
    one_q      <= one_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  dcst_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_spf_ram (
    .clk_i   (clk_i),
    .we_i    (spf_we),
    .waddr_i (spf_waddr),
    .wdata_i (spf_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (spf_rd)
  );

  dcst_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (ed_we),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (exp_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (exp_rd)
  );

  dcst_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ed_we),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (div_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (div_rd)
  );

  dcst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef NO_ASSERTIONS
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == dcst_pkg::S_DDIV1) || (state_q == dcst_pkg::S_DDIV2))
    else $error("divider finished outside a division state");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spf_we || ed_we) |-> (state_q != dcst_pkg::S_IDLE) && (state_q != dcst_pkg::S_Q_OUT))
    else $error("table write outside a build");

  a_cfg_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !ready_q)
    else $error("limit write left tables marked as built");

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result overwritten while waiting");
`endif

endmodule

`default_nettype wire
